// ----- hdl/consistent_hash_ring_lookup_macros.svh -----
// assertion macros for the consistent hash ring lookup block
`ifndef CONSISTENT_HASH_RING_LOOKUP_MACROS_SVH
`define CONSISTENT_HASH_RING_LOOKUP_MACROS_SVH

// same-cycle implication, clocked on clock, off during reset
`define CHRL_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define CHRL_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/chrl_pkg.sv -----
// shared types, constants and codes for the consistent hash ring lookup block
package chrl_pkg;

   localparam int MAX_NODES       = 64;
   localparam int VNODES_PER_NODE = 4;
   localparam int MAX_POINTS      = MAX_NODES * VNODES_PER_NODE;
   localparam int IDX_W           = $clog2(MAX_POINTS);
   localparam int CNT_W           = $clog2(MAX_POINTS + 1);

   localparam int HASH_W = 64;
   localparam int NODE_W = 6;
   localparam int STAT_W = 3;

   localparam logic [HASH_W-1:0] FNV_BASIS     = 64'hcbf29ce484222325;
   localparam logic [8:0]        FNV_PRIME_LOW = 9'h1b3;
   localparam int                FNV_PRIME_SHL = 40;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_KEY  = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_FOUND    = 3'd0;
   localparam logic [STAT_W-1:0] STATUS_EMPTY    = 3'd1;
   localparam logic [STAT_W-1:0] STATUS_INSERTED = 3'd2;
   localparam logic [STAT_W-1:0] STATUS_REPLACED = 3'd3;
   localparam logic [STAT_W-1:0] STATUS_FULL     = 3'd4;

   typedef struct packed {
      logic              operation;
      logic [HASH_W-1:0] hash;
      logic [NODE_W-1:0] node;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_LAST = 4'b0100,
      ST_FIN  = 4'b1000
   } back_state_type;

endpackage

// ----- hdl/chrl_front.sv -----
// front end: accepts items, hashes key bytes and queues loads and lookups
module chrl_front
   import chrl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_operation,
   input  logic [7:0]        req_key_byte,
   input  logic              req_last,
   input  logic [HASH_W-1:0] req_point_hash,
   input  logic [NODE_W-1:0] req_point_node,
   output logic              q_push,
   output cmd_type           q_data,
   input  logic              q_full
);

   logic [HASH_W-1:0] hash_acc_ff;
   logic [HASH_W-1:0] hash_acc_in;
   logic [HASH_W-1:0] mixed;
   logic [HASH_W-1:0] product;
   logic              accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // multiply by the fnv prime: 2^40 plus a small constant
   assign mixed   = hash_acc_ff ^ {{(HASH_W-8){1'b0}}, req_key_byte};
   assign product = (mixed << FNV_PRIME_SHL) + (mixed * HASH_W'(FNV_PRIME_LOW));

   always_comb begin
      hash_acc_in = hash_acc_ff;
      if (accept && req_operation == OP_KEY) begin
         hash_acc_in = req_last ? FNV_BASIS : product;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_acc_ff <= FNV_BASIS;
      end else begin
         hash_acc_ff <= hash_acc_in;
      end
   end

   assign q_push         = accept && (req_operation == OP_LOAD || req_last);
   assign q_data.operation = req_operation;
   assign q_data.hash    = (req_operation == OP_LOAD) ? req_point_hash : product;
   assign q_data.node    = req_point_node;

endmodule

// ----- hdl/chrl_queue.sv -----
// short command queue between the front end and the ring engine
module chrl_queue
   import chrl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   output logic    valid,
   input  logic    pop,
   output cmd_type pop_data
);

   cmd_type              entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff;
   logic [Q_PTR_W-1:0]   wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff;
   logic [Q_PTR_W-1:0]   rd_ptr_in;
   logic [Q_CNT_W-1:0]   cnt_ff;
   logic [Q_CNT_W-1:0]   cnt_in;
   logic                 do_push;
   logic                 do_pop;

   assign full     = (cnt_ff == Q_CNT_W'(Q_DEPTH));
   assign valid    = (cnt_ff != '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ----- hdl/chrl_back.sv -----
// ring engine: point memory, linear scan for loads and successor lookups
module chrl_back
   import chrl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  cmd_type           q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [STAT_W-1:0] rsp_status,
   output logic [NODE_W-1:0] rsp_node_id,
   output logic [HASH_W-1:0] rsp_key_hash
);

   logic [HASH_W-1:0] ring_hash_mem  [MAX_POINTS];
   logic [NODE_W-1:0] ring_owner_mem [MAX_POINTS];

   back_state_type    state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [HASH_W-1:0] rd_hash_ff;
   logic [NODE_W-1:0] rd_owner_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic              rd_vld_ff;
   logic [HASH_W-1:0] min_hash_ff, min_hash_in;
   logic [NODE_W-1:0] min_owner_ff, min_owner_in;
   logic [HASH_W-1:0] ge_hash_ff, ge_hash_in;
   logic [NODE_W-1:0] ge_owner_ff, ge_owner_in;
   logic              have_ge_ff, have_ge_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  match_idx_ff, match_idx_in;
   logic              out_vld_ff, out_vld_in;
   logic [STAT_W-1:0] out_status_ff, out_status_in;
   logic [NODE_W-1:0] out_node_ff, out_node_in;
   logic [HASH_W-1:0] out_hash_ff, out_hash_in;

   logic              hash_we;
   logic              owner_we;
   logic [IDX_W-1:0]  wr_addr;
   logic              take_min;
   logic              take_ge;
   logic              is_match;
   logic              at_last;

   assign take_min = rd_vld_ff && (rd_idx_ff == '0 || rd_hash_ff < min_hash_ff);
   assign take_ge  = rd_vld_ff && (rd_hash_ff >= cmd_ff.hash)
                     && (!have_ge_ff || rd_hash_ff < ge_hash_ff);
   assign is_match = rd_vld_ff && cmd_ff.operation == OP_LOAD && rd_hash_ff == cmd_ff.hash;
   assign at_last  = ({1'b0, idx_ff} == CNT_W'(count_ff - 1'b1));
   assign q_pop    = (state_ff == ST_IDLE) && q_valid && !out_vld_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      min_hash_in   = min_hash_ff;
      min_owner_in  = min_owner_ff;
      ge_hash_in    = ge_hash_ff;
      ge_owner_in   = ge_owner_ff;
      have_ge_in    = have_ge_ff;
      found_in      = found_ff;
      match_idx_in  = match_idx_ff;
      out_vld_in    = out_vld_ff;
      out_status_in = out_status_ff;
      out_node_in   = out_node_ff;
      out_hash_in   = out_hash_ff;
      hash_we       = 1'b0;
      owner_we      = 1'b0;
      wr_addr       = count_ff[IDX_W-1:0];

      if (out_vld_ff && !rsp_stall) begin
         out_vld_in = 1'b0;
      end

      // fold in the entry read last cycle
      if (take_min) begin
         min_hash_in  = rd_hash_ff;
         min_owner_in = rd_owner_ff;
      end
      if (take_ge) begin
         have_ge_in  = 1'b1;
         ge_hash_in  = rd_hash_ff;
         ge_owner_in = rd_owner_ff;
      end
      if (is_match) begin
         found_in     = 1'b1;
         match_idx_in = rd_idx_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               cmd_in     = q_data;
               idx_in     = '0;
               have_ge_in = 1'b0;
               found_in   = 1'b0;
               state_in   = (count_ff == '0) ? ST_FIN : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (at_last) begin
               state_in = ST_LAST;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_LAST: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            out_vld_in = 1'b1;
            if (cmd_ff.operation == OP_LOAD) begin
               out_node_in = cmd_ff.node;
               out_hash_in = '0;
               if (found_ff) begin
                  owner_we      = 1'b1;
                  wr_addr       = match_idx_ff;
                  out_status_in = STATUS_REPLACED;
               end else if (count_ff == CNT_W'(MAX_POINTS)) begin
                  out_status_in = STATUS_FULL;
               end else begin
                  hash_we       = 1'b1;
                  owner_we      = 1'b1;
                  count_in      = count_ff + 1'b1;
                  out_status_in = STATUS_INSERTED;
               end
            end else begin
               out_hash_in = cmd_ff.hash;
               if (count_ff == '0) begin
                  out_status_in = STATUS_EMPTY;
                  out_node_in   = '0;
               end else begin
                  out_status_in = STATUS_FOUND;
                  out_node_in   = have_ge_ff ? ge_owner_ff : min_owner_ff;
               end
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (hash_we) begin
         ring_hash_mem[wr_addr] <= cmd_ff.hash;
      end
      if (owner_we) begin
         ring_owner_mem[wr_addr] <= cmd_ff.node;
      end
      rd_hash_ff  <= ring_hash_mem[idx_ff];
      rd_owner_ff <= ring_owner_mem[idx_ff];
      rd_idx_ff   <= idx_ff;
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      min_hash_ff   <= min_hash_in;
      min_owner_ff  <= min_owner_in;
      ge_hash_ff    <= ge_hash_in;
      ge_owner_ff   <= ge_owner_in;
      match_idx_ff  <= match_idx_in;
      out_status_ff <= out_status_in;
      out_node_ff   <= out_node_in;
      out_hash_ff   <= out_hash_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         rd_vld_ff  <= 1'b0;
         have_ge_ff <= 1'b0;
         found_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rd_vld_ff  <= (state_ff == ST_SCAN);
         have_ge_ff <= have_ge_in;
         found_ff   <= found_in;
         out_vld_ff <= out_vld_in;
      end
   end

   assign rsp_valid    = out_vld_ff;
   assign rsp_status   = out_status_ff;
   assign rsp_node_id  = out_node_ff;
   assign rsp_key_hash = out_hash_ff;

endmodule

// ----- hdl/consistent_hash_ring_lookup.sv -----
// top level of the consistent hash ring lookup block
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  operation, key_byte, last, point_hash, point_node
//   rsp      out        rsp_valid/rsp_stall  status, node_id, key_hash
//
// the front end takes one key byte per cycle while the queue is not full; only the
// last byte of a key and every load reach the ring engine through a two-entry queue
// a load or lookup holds the ring engine while it is taken from the queue, while the
// scan reads one ring point per cycle, through the last and finish states and until
// the result register empties; on an empty ring the scan and last states are skipped
// reset is synchronous; the ring count clears, the point memory is not cleared
// a stalled result holds the engine; the front end keeps hashing until the queue fills
`include "consistent_hash_ring_lookup_macros.svh"

module consistent_hash_ring_lookup
   import chrl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_operation,
   input  logic [7:0]        req_key_byte,
   input  logic              req_last,
   input  logic [HASH_W-1:0] req_point_hash,
   input  logic [NODE_W-1:0] req_point_node,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [STAT_W-1:0] rsp_status,
   output logic [NODE_W-1:0] rsp_node_id,
   output logic [HASH_W-1:0] rsp_key_hash
);

   logic    q_push;
   cmd_type q_push_data;
   logic    q_full;
   logic    q_valid;
   logic    q_pop;
   cmd_type q_pop_data;
   logic    rsp_is_load;

   chrl_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_key_byte   (req_key_byte),
      .req_last       (req_last),
      .req_point_hash (req_point_hash),
      .req_point_node (req_point_node),
      .q_push         (q_push),
      .q_data         (q_push_data),
      .q_full         (q_full)
   );

   chrl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .valid     (q_valid),
      .pop       (q_pop),
      .pop_data  (q_pop_data)
   );

   chrl_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_data       (q_pop_data),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_node_id  (rsp_node_id),
      .rsp_key_hash (rsp_key_hash)
   );

   assign rsp_is_load = rsp_status inside {STATUS_INSERTED, STATUS_REPLACED, STATUS_FULL};

   `CHRL_ASSERT_IMP(a_load_no_hash, rsp_valid && rsp_is_load, rsp_key_hash == '0, "load result carries a key hash")
   `CHRL_ASSERT_IMP(a_empty_no_node, rsp_valid && rsp_status == STATUS_EMPTY, rsp_node_id == '0, "empty ring result")
   `CHRL_ASSERT_NXT(a_pop_spacing, q_pop, !q_pop, "engine took two commands in a row")
   `CHRL_ASSERT_NXT(a_pop_no_result, q_pop, !rsp_valid, "result raised right after a pop")

endmodule
